// ===== rtl/cpsmr_pkg.sv =====
// Shared types and constants for the cut-plane smooth-min radius block.
// Used by the controller, the datapath, the divider and the top level.
package cpsmr_pkg;

  // Input item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_BASE_RADIUS   = 2'd0;
  localparam logic [1:0] REG_EDGE_ROUNDING = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT   = 2'd2;

  // Field widths
  localparam int VEC_W   = 16;
  localparam int DIST_W  = 25;
  localparam int LEN_W   = 24;
  localparam int CNT_W   = 5;
  localparam int ACC_W   = 34;
  localparam int RAD_W   = 42;

  // Shared divider geometry
  localparam int DIV_NUM_W = 53;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  // Facing threshold in Q.28 (largest value not above 1e-4)
  localparam logic signed [ACC_W-1:0] FACING_MIN = 34'sd26843;
  // Floor is base radius over 20: multiply by ceil(2^29 / 20), keep bits from 29 up.
  // Exact for every 24-bit radius.
  localparam int                      FLOOR_RECIP_W = 25;
  localparam logic [FLOOR_RECIP_W-1:0] FLOOR_RECIP  = 25'd26843546;
  localparam int                      FLOOR_SHIFT   = 29;

  typedef enum logic [1:0] {
    DIV_HIT   = 2'd1,
    DIV_SQ    = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    MAC_X = 2'd0,
    MAC_Y = 2'd1,
    MAC_Z = 2'd2
  } mac_sel_t;

  typedef struct packed {
    logic     wr_plane;
    logic     load_query;
    logic     div_start;
    div_sel_t div_sel;
    logic     clr_acc;
    logic     mac_en;
    mac_sel_t mac_sel;
    logic     ld_hit;
    logic     ld_lo_e;
    logic     take_lo;
    logic     ld_sq;
    logic     take_sub;
    logic     inc_idx;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic planes_left;
    logic facing_ok;
    logic plain_min;
    logic div_done;
  } status_t;

endpackage

// ===== rtl/cpsmr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on cpsmr_pkg for its widths.
module cpsmr_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cpsmr_pkg::DIV_NUM_W-1:0]  num,
  input  logic [cpsmr_pkg::DIV_DEN_W-1:0]  den,
  output logic                             done,
  output logic [cpsmr_pkg::DIV_NUM_W-1:0]  quot
);

  logic                              run;
  logic [cpsmr_pkg::DIV_CNT_W-1:0]   cnt;
  logic [cpsmr_pkg::DIV_DEN_W-1:0]   rem;
  logic [cpsmr_pkg::DIV_DEN_W:0]     shifted;
  logic [cpsmr_pkg::DIV_DEN_W:0]     trial;
  logic                              ge;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    shifted = {rem, quot[cpsmr_pkg::DIV_NUM_W-1]};
    ge      = shifted >= {1'b0, den};
    trial   = shifted - {1'b0, den};
  end

  // Control: run for one step per numerator bit
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == cpsmr_pkg::DIV_CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= cpsmr_pkg::DIV_CNT_W'(cpsmr_pkg::DIV_NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == cpsmr_pkg::DIV_CNT_W'(1)) run <= 1'b0;
      end
    end
  end

  // Data: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (run) begin
      quot <= {quot[cpsmr_pkg::DIV_NUM_W-2:0], ge};
      rem  <= ge ? trial[cpsmr_pkg::DIV_DEN_W-1:0] : shifted[cpsmr_pkg::DIV_DEN_W-1:0];
    end
  end

endmodule

// ===== rtl/cpsmr_datapath.sv =====
// Datapath: config registers, plane tables, dot product, divider, smooth min.
// Depends on cpsmr_pkg and cpsmr_div; driven by cpsmr_ctrl commands.
module cpsmr_datapath #(
  parameter int MAX_PLANES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpsmr_pkg::cmd_t                       cmd,
  output cpsmr_pkg::status_t                    status,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [cpsmr_pkg::LEN_W-1:0]           cfg_data,
  input  logic [3:0]                            plane_index,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]    vec_x,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]    vec_y,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]    vec_z,
  input  logic signed [cpsmr_pkg::DIST_W-1:0]   plane_dist,
  output logic [cpsmr_pkg::LEN_W-1:0]           radius
);

  localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CW = $clog2(MAX_PLANES + 1);
  localparam int VW = cpsmr_pkg::VEC_W;
  localparam int RW = cpsmr_pkg::RAD_W;
  localparam int LW = cpsmr_pkg::LEN_W;
  localparam int FPW = LW + cpsmr_pkg::FLOOR_RECIP_W;

  logic [LW-1:0]                 base_radius;
  logic [LW-1:0]                 edge_rounding;
  logic [cpsmr_pkg::CNT_W-1:0]   plane_count;

  logic [3*VW-1:0]               norm_mem [MAX_PLANES];
  logic [cpsmr_pkg::DIST_W-1:0]  dist_mem [MAX_PLANES];
  logic [3*VW-1:0]               rd_norm;
  logic signed [cpsmr_pkg::DIST_W-1:0] rd_dist;

  logic signed [VW-1:0]          qx, qy, qz;
  logic [CW-1:0]                 plane_idx;
  logic [CW-1:0]                 n_eff;
  logic signed [cpsmr_pkg::ACC_W-1:0] acc;
  logic signed [VW-1:0]          mq, mn;
  logic signed [2*VW-1:0]        prod;

  logic                          div_done;
  logic [cpsmr_pkg::DIV_NUM_W-1:0] quot;
  logic [cpsmr_pkg::DIV_NUM_W-1:0] div_num;
  logic [cpsmr_pkg::DIV_DEN_W-1:0] div_den;
  logic [cpsmr_pkg::DIST_W-1:0]  dist_mag;

  logic [FPW-1:0]                floor_prod;
  logic [LW-1:0]                 floor_v;
  logic [LW+1:0]                 far_limit;
  logic signed [RW-1:0]          rad;
  logic signed [RW-1:0]          hit;
  logic signed [RW-1:0]          hit_next;
  logic signed [RW-1:0]          lo;
  logic signed [RW-1:0]          lo_comb;
  logic signed [RW:0]            diff;
  logic [RW:0]                   dmag;
  logic [LW-1:0]                 e;
  logic [2*LW-1:0]               sq;
  logic [LW-1:0]                 out_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_radius   <= LW'(4096);
      edge_rounding <= '0;
      plane_count   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpsmr_pkg::REG_BASE_RADIUS:   base_radius   <= cfg_data;
        cpsmr_pkg::REG_EDGE_ROUNDING: edge_rounding <= cfg_data;
        cpsmr_pkg::REG_PLANE_COUNT:   plane_count   <= cfg_data[cpsmr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Plane tables: write on a plane transfer, registered read at the walk index
  always_ff @(posedge clk) begin
    if (cmd.wr_plane && (int'(plane_index) < MAX_PLANES)) begin
      norm_mem[AW'(plane_index)] <= {vec_x, vec_y, vec_z};
      dist_mem[AW'(plane_index)] <= plane_dist;
    end
    rd_norm <= norm_mem[plane_idx[AW-1:0]];
    rd_dist <= dist_mem[plane_idx[AW-1:0]];
  end

  // Clamp the plane count to the table depth
  always_comb begin
    if (int'(plane_count) > MAX_PLANES) n_eff = CW'(MAX_PLANES);
    else                                n_eff = CW'(plane_count);
  end

  // Query latch and plane walk index
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx <= vec_x;
      qy <= vec_y;
      qz <= vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                 plane_idx <= '0;
    else if (cmd.load_query) plane_idx <= '0;
    else if (cmd.inc_idx)    plane_idx <= plane_idx + 1'b1;
  end

  // Facing: one product per cycle into the accumulator
  always_comb begin
    case (cmd.mac_sel)
      cpsmr_pkg::MAC_X: begin mq = qx; mn = rd_norm[3*VW-1:2*VW]; end
      cpsmr_pkg::MAC_Y: begin mq = qy; mn = rd_norm[2*VW-1:VW];   end
      default:          begin mq = qz; mn = rd_norm[VW-1:0];      end
    endcase
    prod = mq * mn;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc)     acc <= '0;
    else if (cmd.mac_en) acc <= acc + cpsmr_pkg::ACC_W'(prod);
  end

  // Floor: base radius over 20 by reciprocal multiply
  always_comb begin
    floor_prod = FPW'(base_radius) * FPW'(cpsmr_pkg::FLOOR_RECIP);
  end

  // Divider operand selection
  always_comb begin
    dist_mag = rd_dist[cpsmr_pkg::DIST_W-1] ? cpsmr_pkg::DIST_W'(-rd_dist) : rd_dist;
    case (cmd.div_sel)
      cpsmr_pkg::DIV_HIT: begin
        div_num = {dist_mag, 28'b0};
        div_den = acc[cpsmr_pkg::DIV_DEN_W-1:0];
      end
      default: begin
        div_num = cpsmr_pkg::DIV_NUM_W'(sq);
        div_den = cpsmr_pkg::DIV_DEN_W'({edge_rounding, 2'b00});
      end
    endcase
  end

  cpsmr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // Hit distance: sign back, cap non-negative hits at four base radii
  always_comb begin
    far_limit = {base_radius, 2'b00};
    if (rd_dist[cpsmr_pkg::DIST_W-1])
      hit_next = -$signed({1'b0, quot[RW-2:0]});
    else if (quot > cpsmr_pkg::DIV_NUM_W'(far_limit))
      hit_next = $signed(RW'(far_limit));
    else
      hit_next = $signed({1'b0, quot[RW-2:0]});
  end

  // Smooth minimum: minimum, gap and rounding term
  always_comb begin
    diff    = {rad[RW-1], rad} - {hit[RW-1], hit};
    lo_comb = diff[RW] ? rad : hit;
    dmag    = diff[RW] ? (RW+1)'(-diff) : diff;
    e       = edge_rounding - dmag[LW-1:0];
  end

  // Running radius and its helpers
  always_ff @(posedge clk) begin
    if (cmd.load_query) rad <= RW'(base_radius);
    else if (cmd.take_lo) rad <= lo_comb;
    else if (cmd.take_sub) rad <= lo - RW'(quot);
    if (cmd.load_query)
      floor_v <= LW'(floor_prod[FPW-1:cpsmr_pkg::FLOOR_SHIFT]);
    if (cmd.ld_hit)   hit <= hit_next;
    if (cmd.ld_lo_e) begin
      lo   <= lo_comb;
      sq   <= '0;
    end
    if (cmd.ld_sq)    sq <= e * e;
    if (cmd.ld_out)
      out_q <= (rad < $signed(RW'(floor_v))) ? floor_v : rad[LW-1:0];
  end

  assign radius = out_q;

  always_comb begin
    status.planes_left = plane_idx < n_eff;
    status.facing_ok   = acc > cpsmr_pkg::FACING_MIN;
    status.plain_min   = (edge_rounding == '0) ||
                         (dmag >= (RW+1)'(edge_rounding));
    status.div_done    = div_done;
  end

endmodule

// ===== rtl/cpsmr_ctrl.sv =====
// Controller: sequences the plane walk, dot products and divisions.
// Depends on cpsmr_pkg; drives cpsmr_datapath through cmd_t/status_t.
module cpsmr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  cpsmr_pkg::status_t  status,
  output cpsmr_pkg::cmd_t     cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_SQ_GO    = 14'b00000000000010,
    ST_NEXT     = 14'b00000000000100,
    ST_FETCH    = 14'b00000000001000,
    ST_MAC_X    = 14'b00000000010000,
    ST_MAC_Y    = 14'b00000000100000,
    ST_MAC_Z    = 14'b00000001000000,
    ST_TEST     = 14'b00000010000000,
    ST_HIT_WAIT = 14'b00000100000000,
    ST_SMIN     = 14'b00001000000000,
    ST_SQ       = 14'b00010000000000,
    ST_SQ_WAIT  = 14'b00100000000000,
    ST_FINISH   = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = cpsmr_pkg::DIV_HIT;
    cmd.mac_sel = cpsmr_pkg::MAC_X;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == cpsmr_pkg::OP_WRITE) begin
            cmd.wr_plane = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            state_next     = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (status.planes_left) state_next = ST_FETCH;
        else                    state_next = ST_FINISH;
      end
      ST_FETCH: begin
        cmd.clr_acc = 1'b1;
        state_next  = ST_MAC_X;
      end
      ST_MAC_X: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = cpsmr_pkg::MAC_X;
        state_next  = ST_MAC_Y;
      end
      ST_MAC_Y: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = cpsmr_pkg::MAC_Y;
        state_next  = ST_MAC_Z;
      end
      ST_MAC_Z: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = cpsmr_pkg::MAC_Z;
        state_next  = ST_TEST;
      end
      ST_TEST: begin
        if (status.facing_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = cpsmr_pkg::DIV_HIT;
          state_next    = ST_HIT_WAIT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_NEXT;
        end
      end
      ST_HIT_WAIT: begin
        cmd.div_sel = cpsmr_pkg::DIV_HIT;
        if (status.div_done) begin
          cmd.ld_hit = 1'b1;
          state_next = ST_SMIN;
        end
      end
      ST_SMIN: begin
        cmd.ld_lo_e = 1'b1;
        if (status.plain_min) begin
          cmd.take_lo = 1'b1;
          cmd.inc_idx = 1'b1;
          state_next  = ST_NEXT;
        end else begin
          state_next  = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.ld_sq  = 1'b1;
        state_next = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        // Squared term is in place: start the rounding division
        cmd.div_start = 1'b1;
        cmd.div_sel   = cpsmr_pkg::DIV_SQ;
        state_next    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        // Wait for the rounding division, then subtract it
        cmd.div_sel = cpsmr_pkg::DIV_SQ;
        if (status.div_done) begin
          cmd.take_sub = 1'b1;
          cmd.inc_idx  = 1'b1;
          state_next   = ST_NEXT;
        end
      end
      ST_FINISH: begin
        cmd.ld_out = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

`ifndef NO_ASSERTIONS
  // A division finishes only while a wait state is listening for it
  a_div_done_heard: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_HIT_WAIT || state == ST_SQ_WAIT))
    else $error("divider finished outside a wait state");
  // A plain minimum always advances the walk index
  a_smin_plain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SMIN && status.plain_min) |-> cmd.inc_idx)
    else $error("plain minimum did not advance the walk");
`endif

endmodule

// ===== rtl/cut_plane_smooth_min_radius.sv =====
// Cut-plane clipped radius with smooth-minimum rounding, top level.
// Depends on cpsmr_pkg, cpsmr_ctrl, cpsmr_datapath (and cpsmr_div below it).
//
// Usage:
//   Input: raise start with opcode and payload; the item transfers at the
//   edge where start is high and busy is low. A plane write (opcode 0)
//   takes effect in that cycle and leaves busy low, so writes can stream
//   one per cycle. A query (opcode 1) raises busy until its result is out.
//   Result: radius is valid for the single cycle in which done is high; the
//   receiver cannot stall, so the result must be taken then.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is high whenever no query is in flight.
//   Query: the floor is a reciprocal multiply at the transfer; then each
//   plane is fetched and its facing dot product taken; a plane that faces
//   away is skipped, a facing one takes a hit division, and with edge
//   rounding a second, rounding division; then the result is registered.
//   The 1-bit-per-cycle shared divider (53 steps per division) sets the
//   query time. The next item can transfer in the cycle after done.
//   Reset: configuration returns to base radius 1.0, no rounding, no planes;
//   plane table contents are undefined until written.
module cut_plane_smooth_min_radius #(
  parameter int MAX_PLANES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode,
  input  logic [3:0]                           plane_index,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]   vec_x,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]   vec_y,
  input  logic signed [cpsmr_pkg::VEC_W-1:0]   vec_z,
  input  logic signed [cpsmr_pkg::DIST_W-1:0]  plane_dist,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [cpsmr_pkg::LEN_W-1:0]          cfg_data,
  output logic                                 done,
  output logic [cpsmr_pkg::LEN_W-1:0]          radius
);

  cpsmr_pkg::cmd_t    cmd;
  cpsmr_pkg::status_t status;

  assign cfg_ready = ~busy;

  cpsmr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cpsmr_datapath #(
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .plane_index (plane_index),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .plane_dist  (plane_dist),
    .radius      (radius)
  );

`ifndef NO_ASSERTIONS
  // A result appears only while a query holds the block
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without a query in flight");
  // A plane write completes in its transfer cycle
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == cpsmr_pkg::OP_WRITE) |=> !busy)
    else $error("plane write held the block");
  // A query transfer always claims the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == cpsmr_pkg::OP_QUERY) |=> busy)
    else $error("query did not start");
  // The block frees right after delivering a result
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after its result");
`endif

endmodule
